>>> rtl/core/vfls_pkg.sv
// Package for the vibration fault level scorer: word types, widths, codes and reset values.
`default_nettype none

package vfls_pkg;

  // Feature count and field widths.
  localparam int NUM_FEAT   = 7;
  localparam int VALUE_W    = 16;
  localparam int WEIGHT_W   = 8;
  localparam int LVL_THR_W  = 8;
  localparam int POINTS_W   = 2;
  localparam int MAX_POINTS = 3;

  // Derived arithmetic widths.
  localparam int WPTS_W  = $clog2(MAX_POINTS * (2 ** WEIGHT_W - 1) + 1);
  localparam int SCORE_W = $clog2(NUM_FEAT * MAX_POINTS * (2 ** WEIGHT_W - 1) + 1);
  localparam int WSUM_W  = $clog2(NUM_FEAT * (2 ** WEIGHT_W - 1) + 1);
  localparam int AVG_FRAC_W = 6;
  localparam int PROD_W  = LVL_THR_W + WSUM_W;
  localparam int CMP_W   = ((SCORE_W + AVG_FRAC_W) > PROD_W) ? (SCORE_W + AVG_FRAC_W) : PROD_W;

  // Persistence run counter.
  localparam int RUN_W          = 8;
  localparam int PERSIST_DEFAULT = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 56;
  localparam int LEVELS_W   = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEVELS = CFG_IDX_W'(NUM_FEAT);

  // Points and fault level codes.
  localparam logic [POINTS_W-1:0] PTS_NONE   = 2'd0;
  localparam logic [POINTS_W-1:0] PTS_WARN   = 2'd1;
  localparam logic [POINTS_W-1:0] PTS_DANGER = 2'd2;
  localparam logic [POINTS_W-1:0] PTS_CRIT   = 2'd3;

  localparam logic [1:0] LVL_NORMAL  = 2'd0;
  localparam logic [1:0] LVL_WARNING = 2'd1;
  localparam logic [1:0] LVL_DANGER  = 2'd2;
  localparam logic [1:0] LVL_CRIT    = 2'd3;

  // Per-feature setup register, packed as on the configuration port.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [VALUE_W-1:0]  crit;
    logic [VALUE_W-1:0]  danger;
    logic [VALUE_W-1:0]  warn;
  } setup_t;

  // Average score level register.
  typedef struct packed {
    logic [LVL_THR_W-1:0] crit;
    logic [LVL_THR_W-1:0] danger;
    logic [LVL_THR_W-1:0] warn;
  } levels_t;

  localparam setup_t  SETUP_RESET  = 56'h0010FFFFFFFFFFFF;
  localparam levels_t LEVELS_RESET = 24'hC08040;

  // Input word.
  typedef struct packed {
    logic [VALUE_W-1:0] rms_value;
    logic [VALUE_W-1:0] peak_value;
    logic [VALUE_W-1:0] kurtosis_value;
    logic [VALUE_W-1:0] crest_value;
    logic [VALUE_W-1:0] clearance_value;
    logic [VALUE_W-1:0] impulse_value;
    logic [VALUE_W-1:0] form_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic       reported;
    logic [1:0] fault_level;
  } out_word_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic [WPTS_W-1:0]   wpts;
    logic [WEIGHT_W-1:0] weight;
  } lane_res_t;

endpackage

`default_nettype wire

>>> rtl/core/vfls_lane.sv
// One scoring lane: grades a feature against its thresholds and weights the points.
`default_nettype none

module vfls_lane
  import vfls_pkg::*;
(
  input  wire logic [VALUE_W-1:0] value,
  input  wire setup_t             setup,
  output lane_res_t               res
);

  logic [POINTS_W-1:0] points;

  // Thresholds are tested critical first; the first one met decides.
  always_comb begin
    if (value >= setup.crit) begin
      points = PTS_CRIT;
    end else if (value >= setup.danger) begin
      points = PTS_DANGER;
    end else if (value >= setup.warn) begin
      points = PTS_WARN;
    end else begin
      points = PTS_NONE;
    end
  end

  // Weighted points and the weight itself for the sums.
  assign res.wpts   = WPTS_W'(points) * WPTS_W'(setup.weight);
  assign res.weight = setup.weight;

endmodule

`default_nettype wire

>>> rtl/core/vfls_merge.sv
// Merging stages: sums the lane results, then grades the weighted average.
`default_nettype none

module vfls_merge
  import vfls_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lane_res_t lane_res [NUM_FEAT],
  input  wire levels_t   levels,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [1:0]     out_level
);

  logic               sum_valid_r, sum_valid_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [WSUM_W-1:0]  wsum_r, wsum_nxt;
  logic               lvl_valid_r, lvl_valid_nxt;
  logic [1:0]         level_r, level_nxt;
  logic               sum_ready, lvl_ready;
  logic               met_crit, met_danger, met_warn;

  // The average meets a level when 64*score >= level*wsum; a zero weight sum
  // counts as an average of zero.
  function automatic logic level_met(input logic [SCORE_W-1:0]  score,
                                     input logic [WSUM_W-1:0]   wsum,
                                     input logic [LVL_THR_W-1:0] lvl);
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    lhs = CMP_W'({score, {AVG_FRAC_W{1'b0}}});
    rhs = CMP_W'(PROD_W'(lvl) * PROD_W'(wsum));
    if (wsum == '0) begin
      return (lvl == '0);
    end
    return (lhs >= rhs);
  endfunction

  // Handshake between the two stages.
  assign lvl_ready = !lvl_valid_r || out_ready;
  assign sum_ready = !sum_valid_r || lvl_ready;
  assign in_ready  = sum_ready;

  // Sum stage: score and weight sums over all lanes.
  always_comb begin
    score_nxt = '0;
    wsum_nxt  = '0;
    for (int i = 0; i < NUM_FEAT; i++) begin
      score_nxt = score_nxt + SCORE_W'(lane_res[i].wpts);
      wsum_nxt  = wsum_nxt + WSUM_W'(lane_res[i].weight);
    end
    sum_valid_nxt = sum_ready ? in_valid : sum_valid_r;
  end

  // Level stage: critical first, then danger, then warning.
  always_comb begin
    met_crit   = level_met(score_r, wsum_r, levels.crit);
    met_danger = level_met(score_r, wsum_r, levels.danger);
    met_warn   = level_met(score_r, wsum_r, levels.warn);
    if (met_crit) begin
      level_nxt = LVL_CRIT;
    end else if (met_danger) begin
      level_nxt = LVL_DANGER;
    end else if (met_warn) begin
      level_nxt = LVL_WARNING;
    end else begin
      level_nxt = LVL_NORMAL;
    end
    lvl_valid_nxt = lvl_ready ? sum_valid_r : lvl_valid_r;
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
      lvl_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= sum_valid_nxt;
      lvl_valid_r <= lvl_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sum_ready && in_valid) begin
      score_r <= score_nxt;
      wsum_r  <= wsum_nxt;
    end
    if (lvl_ready && sum_valid_r) begin
      level_r <= level_nxt;
    end
  end

  assign out_valid = lvl_valid_r;
  assign out_level = level_r;

endmodule

`default_nettype wire

>>> rtl/core/vfls_persist.sv
// Persistence filter and result register.
`default_nettype none

module vfls_persist
  import vfls_pkg::*;
#(
  parameter int PERSIST_LENGTH = PERSIST_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_level,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_data
);

  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(PERSIST_LENGTH);
  localparam logic [RUN_W-1:0] RUN_ONE = RUN_W'(1);

  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;
  logic [1:0]       last_level_r, last_level_nxt;
  logic [RUN_W-1:0] run_length_r, run_length_nxt;
  logic             load;

  assign in_ready = !out_valid_r || !out_stall;
  assign load     = in_valid && in_ready;

  // Run count saturates at the persistence length; a new level restarts it.
  always_comb begin
    if (in_level == last_level_r) begin
      last_level_nxt = last_level_r;
      run_length_nxt = (run_length_r < RUN_MAX) ? run_length_r + RUN_ONE : run_length_r;
    end else begin
      last_level_nxt = in_level;
      run_length_nxt = RUN_ONE;
    end
    out_nxt.reported    = (run_length_nxt >= RUN_MAX);
    out_nxt.fault_level = in_level;
    out_valid_nxt       = in_ready ? in_valid : out_valid_r;
  end

  // Control state; the history starts as if full of normal levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_level_r <= LVL_NORMAL;
      run_length_r <= RUN_MAX;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        last_level_r <= last_level_nxt;
        run_length_r <= run_length_nxt;
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (run_length_r >= RUN_ONE) && (run_length_r <= RUN_MAX))
    else $error("run length out of range");

  a_change_not_reported: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (in_level != last_level_r) && (RUN_MAX != RUN_ONE)) |=> !out_r.reported)
    else $error("level change reported at once");

  a_out_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.fault_level == last_level_r))
    else $error("result level differs from tracked level");
`endif

endmodule

`default_nettype wire

>>> rtl/core/vibration_fault_level_scorer_top.sv
// Top level of the vibration fault level scorer: configuration, lanes and pipeline.
//
//   Channel  Direction  Handshake          Word
//   in_      input      in_valid/in_stall  in_word_t, seven Q8.8 features
//   out_     output     out_valid/out_stall out_word_t, reported and fault_level
//   cfg_     input      cfg_valid/cfg_ready register index and 56-bit data
//
// One word is accepted per cycle while in_stall is low; each result passes the lane, sum,
// level and result registers in that order after its word is accepted.
// The depth is set by the seven-lane sum and the three level multipliers.
// Reset is synchronous; it restores all setups, the levels and the filter history.
// A stalled output holds its word; stages before it keep filling until full.
`default_nettype none

module vibration_fault_level_scorer_top
  import vfls_pkg::*;
#(
  parameter int PERSIST_LENGTH = PERSIST_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  setup_t             setup_r [NUM_FEAT];
  levels_t            levels_r;
  logic [VALUE_W-1:0] feat [NUM_FEAT];
  lane_res_t          lane_res [NUM_FEAT];
  lane_res_t          lane_r [NUM_FEAT];
  logic               lane_valid_r, lane_valid_nxt;
  logic               lane_ready, merge_ready;
  logic               lvl_valid, lvl_ready;
  logic [1:0]         lvl;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FEAT; i++) begin
        setup_r[i] <= SETUP_RESET;
      end
      levels_r <= LEVELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < NUM_FEAT; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          setup_r[i] <= cfg_data;
        end
      end
      if (cfg_index == CFG_IDX_LEVELS) begin
        levels_r <= cfg_data[LEVELS_W-1:0];
      end
    end
  end

  // Features in lane order.
  assign feat[0] = in_data.rms_value;
  assign feat[1] = in_data.peak_value;
  assign feat[2] = in_data.kurtosis_value;
  assign feat[3] = in_data.crest_value;
  assign feat[4] = in_data.clearance_value;
  assign feat[5] = in_data.impulse_value;
  assign feat[6] = in_data.form_value;

  // Scoring lanes, one per feature.
  for (genvar g = 0; g < NUM_FEAT; g++) begin : g_lane
    vfls_lane u_lane (
      .value (feat[g]),
      .setup (setup_r[g]),
      .res   (lane_res[g])
    );
  end

  // Lane register stage.
  assign lane_ready     = !lane_valid_r || merge_ready;
  assign in_stall       = !lane_ready;
  assign lane_valid_nxt = lane_ready ? in_valid : lane_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_valid_r <= 1'b0;
    end else begin
      lane_valid_r <= lane_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready && in_valid) begin
      for (int i = 0; i < NUM_FEAT; i++) begin
        lane_r[i] <= lane_res[i];
      end
    end
  end

  // Merging stages.
  vfls_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lane_valid_r),
    .in_ready  (merge_ready),
    .lane_res  (lane_r),
    .levels    (levels_r),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_level (lvl)
  );

  // Persistence filter and result register.
  vfls_persist #(
    .PERSIST_LENGTH (PERSIST_LENGTH)
  ) u_persist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lvl_valid),
    .in_ready  (lvl_ready),
    .in_level  (lvl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
